// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Opcodes and status codes shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- src/complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// ----------------------------------------------------------------------------
// A request is taken at a rising clock edge with start high and busy low.
// busy is always low, so one request may enter every cycle. Each request
// gives one result, shown for one cycle on the rsp_ ports with rsp_strobe
// high, in request order. The receiver cannot stall the result stream.
// The pipeline from the accepting edge to the result holds one input
// register, one multiplier stage, one combine stage, one setup stage for
// the divider, PART_WIDTH restoring divider stages (one quotient bit each)
// and one output register with saturation. Every opcode travels the full
// pipeline, so the latency does not depend on the operation. The quotient
// length is set by the divider stage count. Reset clears the valid bits
// of all stages; requests in flight are dropped and no result is produced
// for them. Status is 0 for ok, 1 when a part saturated and 2 for a zero
// divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS  = 8,
   parameter int PART_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [1:0]                   req_opcode,
   input  wire  signed [PART_WIDTH-1:0] req_a_real,
   input  wire  signed [PART_WIDTH-1:0] req_a_imag,
   input  wire  signed [PART_WIDTH-1:0] req_b_real,
   input  wire  signed [PART_WIDTH-1:0] req_b_imag,
   output logic                         rsp_strobe,
   output logic signed [PART_WIDTH-1:0] rsp_res_real,
   output logic signed [PART_WIDTH-1:0] rsp_res_imag,
   output logic [1:0]                   rsp_status
);

   localparam int W  = PART_WIDTH;
   localparam int PW = 2 * PART_WIDTH;
   localparam int NW = 2 * PART_WIDTH + 1;
   localparam int RW = NW + FRAC_BITS + PART_WIDTH;

   // Stage 1: input register.
   logic                v1_ff;
   op_type              op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // Stage 2: products.
   logic                 v2_ff;
   op_type               op2_ff;
   logic signed [W-1:0]  ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [PW-1:0] prr2_ff, pii2_ff, pri2_ff, pir2_ff, pbr2_ff, pbi2_ff;

   // Stage 3: combined values and divisor magnitude.
   logic                 v3_ff;
   op_type               op3_ff;
   logic signed [NW-1:0] re3_ff, im3_ff, re3_in, im3_in;
   logic [NW-1:0]        den3_ff;

   // Divider pipeline, index 0 is the setup stage.
   logic                 dv_ff      [W+1];
   op_type               dop_ff     [W+1];
   logic signed [NW-1:0] dre_ff     [W+1];
   logic signed [NW-1:0] dim_ff     [W+1];
   logic [NW-1:0]        dden_ff    [W+1];
   logic [RW-1:0]        drem_re_ff [W+1];
   logic [RW-1:0]        drem_im_ff [W+1];
   logic [W-1:0]         dq_re_ff   [W+1];
   logic [W-1:0]         dq_im_ff   [W+1];
   logic                 dneg_re_ff [W+1];
   logic                 dneg_im_ff [W+1];
   logic                 dovf_re_ff [W+1];
   logic                 dovf_im_ff [W+1];

   logic [NW-1:0] mag_re, mag_im;
   logic [RW-1:0] dvd_re, dvd_im, den_top;

   logic signed [W-1:0] res_re_in, res_im_in;
   logic [1:0]          status_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      op1_ff  <= op_type'(req_opcode);
      ar1_ff  <= req_a_real;
      ai1_ff  <= req_a_imag;
      br1_ff  <= req_b_real;
      bi1_ff  <= req_b_imag;
      op2_ff  <= op1_ff;
      ar2_ff  <= ar1_ff;
      ai2_ff  <= ai1_ff;
      br2_ff  <= br1_ff;
      bi2_ff  <= bi1_ff;
      prr2_ff <= ar1_ff * br1_ff;
      pii2_ff <= ai1_ff * bi1_ff;
      pri2_ff <= ar1_ff * bi1_ff;
      pir2_ff <= ai1_ff * br1_ff;
      pbr2_ff <= br1_ff * br1_ff;
      pbi2_ff <= bi1_ff * bi1_ff;
      op3_ff  <= op2_ff;
      re3_ff  <= re3_in;
      im3_ff  <= im3_in;
      den3_ff <= NW'(unsigned'(pbr2_ff)) + NW'(unsigned'(pbi2_ff));
   end

   // Multiply results use an arithmetic shift, which rounds toward minus
   // infinity. Divide carries the conjugate product numerators.
   always_comb begin
      unique case (op2_ff)
         OP_ADD: begin
            re3_in = NW'(ar2_ff) + NW'(br2_ff);
            im3_in = NW'(ai2_ff) + NW'(bi2_ff);
         end
         OP_SUB: begin
            re3_in = NW'(ar2_ff) - NW'(br2_ff);
            im3_in = NW'(ai2_ff) - NW'(bi2_ff);
         end
         OP_MUL: begin
            re3_in = (NW'(prr2_ff) - NW'(pii2_ff)) >>> FRAC_BITS;
            im3_in = (NW'(pri2_ff) + NW'(pir2_ff)) >>> FRAC_BITS;
         end
         default: begin
            re3_in = NW'(prr2_ff) + NW'(pii2_ff);
            im3_in = NW'(pir2_ff) - NW'(pri2_ff);
         end
      endcase
   end

   // Setup: magnitudes, shifted dividends and the overflow check against
   // a quotient of PART_WIDTH bits.
   always_comb begin
      mag_re  = re3_ff[NW-1] ? NW'(-re3_ff) : NW'(re3_ff);
      mag_im  = im3_ff[NW-1] ? NW'(-im3_ff) : NW'(im3_ff);
      dvd_re  = RW'(mag_re) << FRAC_BITS;
      dvd_im  = RW'(mag_im) << FRAC_BITS;
      den_top = RW'(den3_ff) << W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v3_ff;
      end
      dop_ff[0]     <= op3_ff;
      dre_ff[0]     <= re3_ff;
      dim_ff[0]     <= im3_ff;
      dden_ff[0]    <= den3_ff;
      drem_re_ff[0] <= dvd_re;
      drem_im_ff[0] <= dvd_im;
      dq_re_ff[0]   <= '0;
      dq_im_ff[0]   <= '0;
      dneg_re_ff[0] <= re3_ff[NW-1];
      dneg_im_ff[0] <= im3_ff[NW-1];
      dovf_re_ff[0] <= dvd_re >= den_top;
      dovf_im_ff[0] <= dvd_im >= den_top;
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int SH = W - 1 - k;
      logic [RW-1:0] trial;
      logic          take_re, take_im;

      always_comb begin
         trial   = RW'(dden_ff[k]) << SH;
         take_re = drem_re_ff[k] >= trial;
         take_im = drem_im_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else begin
            dv_ff[k+1] <= dv_ff[k];
         end
         dop_ff[k+1]     <= dop_ff[k];
         dre_ff[k+1]     <= dre_ff[k];
         dim_ff[k+1]     <= dim_ff[k];
         dden_ff[k+1]    <= dden_ff[k];
         drem_re_ff[k+1] <= take_re ? drem_re_ff[k] - trial : drem_re_ff[k];
         drem_im_ff[k+1] <= take_im ? drem_im_ff[k] - trial : drem_im_ff[k];
         dq_re_ff[k+1]   <= dq_re_ff[k] | (W'(take_re) << SH);
         dq_im_ff[k+1]   <= dq_im_ff[k] | (W'(take_im) << SH);
         dneg_re_ff[k+1] <= dneg_re_ff[k];
         dneg_im_ff[k+1] <= dneg_im_ff[k];
         dovf_re_ff[k+1] <= dovf_re_ff[k];
         dovf_im_ff[k+1] <= dovf_im_ff[k];
      end
   end

   function automatic logic [W:0] sat_val(input logic signed [NW-1:0] v);
      logic [NW-W:0] top;
      logic          over;
      top  = v[NW-1:W-1];
      over = (top != '0) && (top != '1);
      if (over) begin
         sat_val = v[NW-1] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
         sat_val = {1'b0, v[W-1:0]};
      end
   endfunction

   function automatic logic [W:0] sat_quot(input logic [W-1:0] q, input logic neg,
                                           input logic ovf);
      logic [W-1:0] half;
      half = W'(1) << (W - 1);
      if (neg && (ovf || q > half)) begin
         sat_quot = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else if (neg) begin
         sat_quot = {1'b0, W'(~q + W'(1))};
      end else if (ovf || q[W-1]) begin
         sat_quot = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
         sat_quot = {1'b0, q};
      end
   endfunction

   always_comb begin
      logic [W:0] r_re, r_im;
      if (dop_ff[W] == OP_DIV) begin
         r_re = sat_quot(dq_re_ff[W], dneg_re_ff[W], dovf_re_ff[W]);
         r_im = sat_quot(dq_im_ff[W], dneg_im_ff[W], dovf_im_ff[W]);
      end else begin
         r_re = sat_val(dre_ff[W]);
         r_im = sat_val(dim_ff[W]);
      end
      if (dop_ff[W] == OP_DIV && dden_ff[W] == '0) begin
         res_re_in = '0;
         res_im_in = '0;
         status_in = ST_DZ;
      end else begin
         res_re_in = r_re[W-1:0];
         res_im_in = r_im[W-1:0];
         status_in = (r_re[W] || r_im[W]) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= dv_ff[W];
      end
      rsp_res_real <= res_re_in;
      rsp_res_imag <= res_im_in;
      rsp_status   <= status_in;
   end

endmodule

`default_nettype wire
